>>> rtl/core/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// Types and constants shared by the timer job scheduler modules.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int MAX_RESULTS = 16;
  localparam int QDEPTH = 2;

  localparam logic [1:0] FUNC_SUBMIT = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [1:0] KIND_DISPATCH = 2'd0;
  localparam logic [1:0] KIND_GRANT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [1:0] PRI_HIGH = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [15:0] job_tag;
    logic [1:0] priority_req;
    logic [15:0] delay;
    logic repeat_req;
    logic [15:0] interval;
    logic [3:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot;
    logic [15:0] tag_out;
    logic [1:0] priority_out;
    logic last;
    logic [4:0] waiting_count;
  } out_item_t;

  // Classified command passed from the front part to the back part.
  typedef struct packed {
    logic [1:0] func;
    logic [15:0] job_tag;
    logic [1:0] pri;
    logic [15:0] delay;
    logic repeat_req;
    logic [15:0] interval;
    logic cancel_ok;
    logic [SLOT_W-1:0] handle;
  } cmd_t;

endpackage

>>> rtl/core/ptts_front.sv
// ----------------------------------------------------------------------------
// ptts_front
// Accepts command transactions, normalizes them and queues them; function code 3 is dropped.
// ----------------------------------------------------------------------------
module ptts_front (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  ptts_pkg::in_item_t in_item,
  output logic cmd_valid,
  output ptts_pkg::cmd_t cmd,
  input  logic cmd_pop
);
  import ptts_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  cmd_t q_r [QDEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0] cnt_r, cnt_nxt;
  logic push;
  cmd_t c;

  assign busy = (cnt_r == (PW+1)'(QDEPTH));
  assign push = start && !busy && (in_item.func != 2'd3);
  assign cmd_valid = (cnt_r != '0);
  assign cmd = q_r[rp_r];

  always_comb begin
    c.func = in_item.func;
    c.job_tag = in_item.job_tag;
    c.pri = (in_item.priority_req > PRI_HIGH) ? PRI_HIGH : in_item.priority_req;
    c.delay = in_item.delay;
    c.repeat_req = in_item.repeat_req;
    c.interval = in_item.interval;
    c.cancel_ok = (32'(in_item.handle) < SLOTS);
    c.handle = SLOT_W'(in_item.handle);
    wp_nxt = push ? wp_r + PW'(1) : wp_r;
    rp_nxt = cmd_pop ? rp_r + PW'(1) : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= c;
    end
  end
endmodule

>>> rtl/core/ptts_back.sv
// ----------------------------------------------------------------------------
// ptts_back
// Holds the slot table and carries out submit, cancel and tick commands.
// ----------------------------------------------------------------------------
module ptts_back (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  ptts_pkg::cmd_t cmd,
  output logic cmd_pop,
  output logic out_valid,
  output ptts_pkg::out_item_t out_item
);
  import ptts_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUB2 = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_PICK = 2'd3;
  localparam int NW = $clog2(MAX_RESULTS + 1);

  logic [SLOTS-1:0] valid_r, valid_nxt, pend_r, pend_nxt;
  logic [1:0] pri_r [SLOTS];
  logic [31:0] due_r [SLOTS];
  logic [15:0] iv_r [SLOTS];
  logic rep_r [SLOTS];
  logic [15:0] tag_r [SLOTS];
  logic [31:0] now_r, now_nxt;
  logic [1:0] st_r, st_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [SLOT_W-1:0] sub_r;
  logic [SLOT_W:0] scan_r, scan_nxt;
  logic best_ok_r, best_ok_nxt;
  logic [SLOT_W-1:0] best_r, best_nxt;
  logic [31:0] best_late_r, best_late_nxt;
  logic [SLOT_W-1:0] free_idx;
  logic free_ok;
  logic [CNT_W-1:0] cnt_now;
  logic out_valid_nxt;
  out_item_t o_nxt;
  logic wr_sub, wr_due;
  logic [SLOT_W-1:0] wr_idx;
  logic [31:0] due_val;
  logic [31:0] late;
  logic [SLOT_W-1:0] si;
  logic [CNT_W-1:0] cnt_fut;
  logic [SLOTS-1:0] rep_vec;

  always_comb begin
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_ok = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      rep_vec[i] = rep_r[i];
    end
  end

  function automatic logic [CNT_W-1:0] popc(input logic [SLOTS-1:0] v);
    logic [CNT_W-1:0] s;
    s = '0;
    for (int i = 0; i < SLOTS; i++) begin
      s = s + CNT_W'(v[i]);
    end
    return s;
  endfunction

  assign cnt_now = popc(valid_nxt);
  assign si = scan_r[SLOT_W-1:0];
  assign late = now_r - due_r[si];

  always_comb begin
    st_nxt = st_r;
    valid_nxt = valid_r;
    pend_nxt = pend_r;
    now_nxt = now_r;
    n_nxt = n_r;
    scan_nxt = scan_r;
    best_ok_nxt = best_ok_r;
    best_nxt = best_r;
    best_late_nxt = best_late_r;
    cmd_pop = 1'b0;
    out_valid_nxt = 1'b0;
    o_nxt = '0;
    wr_sub = 1'b0;
    wr_due = 1'b0;
    wr_idx = free_idx;
    due_val = '0;
    cnt_fut = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.func)
            FUNC_SUBMIT: begin
              out_valid_nxt = 1'b1;
              o_nxt.tag_out = cmd.job_tag;
              o_nxt.priority_out = cmd.pri;
              o_nxt.last = 1'b1;
              if (!free_ok) begin
                o_nxt.kind = KIND_REJECT;
                o_nxt.waiting_count = 5'(popc(valid_r));
              end else begin
                wr_sub = 1'b1;
                o_nxt.kind = KIND_GRANT;
                o_nxt.slot = 4'(free_idx);
                if (cmd.repeat_req) begin
                  wr_due = 1'b1;
                  due_val = now_r + ((cmd.interval == '0) ? 32'd1 : 32'(cmd.interval));
                  valid_nxt[free_idx] = 1'b1;
                end else if (cmd.delay == '0) begin
                  o_nxt.last = 1'b0;
                  st_nxt = ST_SUB2;
                end else begin
                  wr_due = 1'b1;
                  due_val = now_r + 32'(cmd.delay);
                  valid_nxt[free_idx] = 1'b1;
                end
                o_nxt.waiting_count = 5'(popc(valid_nxt));
              end
            end
            FUNC_CANCEL: begin
              if (cmd.cancel_ok) begin
                valid_nxt[cmd.handle] = 1'b0;
              end
            end
            FUNC_TICK: begin
              now_nxt = now_r + 32'd1;
              n_nxt = '0;
              scan_nxt = '0;
              best_ok_nxt = 1'b0;
              pend_nxt = '0;
              st_nxt = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SUB2: begin
        out_valid_nxt = 1'b1;
        o_nxt.kind = KIND_DISPATCH;
        o_nxt.slot = 4'(sub_r);
        o_nxt.tag_out = tag_r[sub_r];
        o_nxt.priority_out = pri_r[sub_r];
        o_nxt.last = 1'b1;
        o_nxt.waiting_count = 5'(popc(valid_r));
        st_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        // One slot per cycle: mark due jobs and track the best candidate.
        if (valid_r[si] && !late[31]) begin
          pend_nxt[si] = 1'b1;
          if (!best_ok_nxt || pri_r[si] > pri_r[best_r] ||
              (pri_r[si] == pri_r[best_r] && late > best_late_r)) begin
            best_ok_nxt = 1'b1;
            best_nxt = si;
            best_late_nxt = late;
          end
        end
        scan_nxt = scan_r + (SLOT_W+1)'(1);
        if (scan_r == (SLOT_W+1)'(SLOTS - 1)) begin
          st_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        if (!best_ok_r) begin
          st_nxt = ST_IDLE;
        end else begin
          pend_nxt[best_r] = 1'b0;
          if (rep_r[best_r]) begin
            wr_due = 1'b1;
            wr_idx = best_r;
            due_val = now_r + ((iv_r[best_r] == '0) ? 32'd1 : 32'(iv_r[best_r]));
          end else begin
            valid_nxt[best_r] = 1'b0;
          end
          n_nxt = n_r + NW'(1);
          best_ok_nxt = 1'b0;
          scan_nxt = '0;
          if (pend_nxt == '0 || n_nxt == NW'(MAX_RESULTS)) begin
            st_nxt = ST_IDLE;
          end else begin
            st_nxt = ST_SCAN;
          end
          // Count after the whole tick: the non-repeating jobs still pending will be freed.
          cnt_fut = popc(valid_nxt & ~(pend_nxt & ~rep_vec));
          out_valid_nxt = 1'b1;
          o_nxt.kind = KIND_DISPATCH;
          o_nxt.slot = 4'(best_r);
          o_nxt.tag_out = tag_r[best_r];
          o_nxt.priority_out = pri_r[best_r];
          o_nxt.last = (st_nxt == ST_IDLE);
          o_nxt.waiting_count = 5'(cnt_fut);
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      valid_r <= '0;
      pend_r <= '0;
      now_r <= '0;
      n_r <= '0;
      scan_r <= '0;
      best_ok_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      valid_r <= valid_nxt;
      pend_r <= pend_nxt;
      now_r <= now_nxt;
      n_r <= n_nxt;
      scan_r <= scan_nxt;
      best_ok_r <= best_ok_nxt;
      out_valid <= out_valid_nxt;
    end
    best_r <= best_nxt;
    best_late_r <= best_late_nxt;
    out_item <= o_nxt;
    if (wr_sub) begin
      sub_r <= free_idx;
      tag_r[free_idx] <= cmd.job_tag;
      pri_r[free_idx] <= cmd.pri;
      rep_r[free_idx] <= cmd.repeat_req;
      iv_r[free_idx] <= cmd.interval;
    end
    if (wr_due) begin
      due_r[wr_idx] <= due_val;
    end
  end
endmodule

>>> rtl/core/priority_timer_task_scheduler.sv
// ----------------------------------------------------------------------------
// priority_timer_task_scheduler
// Slot table of timed jobs with priority-ordered dispatch on each tick.
// ----------------------------------------------------------------------------
// The back part takes each command from the queue in its idle state. With the
// back part idle, a submit strobes its grant from the registered output, and a
// one-shot job with zero delay then strobes its dispatch from the ST_SUB2 state;
// a cancel gives no result. A tick scans the slot table one slot per cycle in
// ST_SCAN and then emits the best due job from ST_PICK, repeating scan and
// dispatch for each due job. A two-entry command queue lets new transactions
// enter while a tick runs; busy is high while it is full. Results appear on
// out_valid for one cycle each and cannot be held off.
module priority_timer_task_scheduler (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  ptts_pkg::in_item_t in_item,
  output logic out_valid,
  output ptts_pkg::out_item_t out_item
);
  import ptts_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  ptts_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  ptts_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_pop(cmd_pop), .out_valid(out_valid), .out_item(out_item)
  );
endmodule
